// ----- rtl/percent_decoder_core_defines.svh -----
// Assertion macros shared by the percent decoder RTL.
// Depends on a clock named clock and a synchronous reset named reset in scope.
`ifndef PERCENT_DECODER_CORE_DEFINES_SVH
`define PERCENT_DECODER_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define PCTD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define PCTD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/pctd_pkg.sv -----
// Types, constants and helper functions for the percent decoder.
// No dependencies; imported by every percent decoder module.
`default_nettype none

package pctd_pkg;

   localparam logic [7:0] PCT_CHAR = 8'h25;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   typedef enum logic [1:0] {
      PEND_IDLE  = 2'd0,
      PEND_PCT   = 2'd1,
      PEND_DIGIT = 2'd2
   } pend_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] bytes;
      logic            last;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.valid = 1'b1;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.value = 4'(c - 8'h41 + 8'd10);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.value = 4'(c - 8'h61 + 8'd10);
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/percent_decoder_core.sv -----
// URI percent decoder: one encoded byte per item, "%hh" escapes become one byte.
// Accepts one item per cycle while the command queue has room; each item yields
// zero to three result items, and results leave one per cycle while rsp_stall is
// low, from a registered output stage, so sustained throughput is set by the
// result port at one byte per cycle. An accepted item's results pass the command
// queue, then the output register. A '%' held when the last item arrives, or a
// '%' plus digit the last item does not complete, is flushed raw, and the final
// result of that item carries out_last. QUEUE_DEPTH sets the command queue size.
`default_nettype none

module percent_decoder_core
   import pctd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_item,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_item
);

   q_status_type q_status;
   logic         push;
   logic         pop;
   cmd_type      push_cmd;
   cmd_type      head_cmd;

   pctd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .q_status  (q_status),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   pctd_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .q_status (q_status),
      .head_cmd (head_cmd)
   );

   pctd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_cmd  (head_cmd),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

// ----- rtl/pctd_front.sv -----
// Front end: accepts items, tracks pending escape bytes, builds result commands.
// Depends on pctd_pkg.
`default_nettype none

module pctd_front
   import pctd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_type      req_item,
   input  wire q_status_type q_status,
   output logic              push,
   output cmd_type           push_cmd
);

   pend_type   pend_ff, pend_in;
   logic [7:0] digit_char_ff, digit_char_in;
   logic [3:0] digit_value_ff, digit_value_in;
   logic       accept;
   logic       scan_pct;
   hex_type    hex;
   cmd_type    cmd;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign hex       = hex_decode(req_item.in_byte);
   assign scan_pct  = (req_item.in_byte == PCT_CHAR) && !req_item.in_last;

   always_comb begin
      pend_in        = pend_ff;
      digit_char_in  = digit_char_ff;
      digit_value_in = digit_value_ff;
      if (accept) begin
         unique case (pend_ff)
            PEND_PCT: begin
               if (hex.valid && !req_item.in_last) begin
                  pend_in        = PEND_DIGIT;
                  digit_char_in  = req_item.in_byte;
                  digit_value_in = hex.value;
               end else begin
                  pend_in = scan_pct ? PEND_PCT : PEND_IDLE;
               end
            end
            PEND_DIGIT: begin
               if (hex.valid) begin
                  pend_in = PEND_IDLE;
               end else begin
                  pend_in = scan_pct ? PEND_PCT : PEND_IDLE;
               end
            end
            default: begin
               pend_in = scan_pct ? PEND_PCT : PEND_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      cmd       = '0;
      cmd.last  = req_item.in_last;
      unique case (pend_ff)
         PEND_PCT: begin
            if (hex.valid && !req_item.in_last) begin
               cmd.count = 2'd0;
            end else begin
               cmd.bytes[0] = PCT_CHAR;
               if (scan_pct) begin
                  cmd.count = 2'd1;
               end else begin
                  cmd.bytes[1] = req_item.in_byte;
                  cmd.count    = 2'd2;
               end
            end
         end
         PEND_DIGIT: begin
            if (hex.valid) begin
               cmd.bytes[0] = {digit_value_ff, hex.value};
               cmd.count    = 2'd1;
            end else begin
               cmd.bytes[0] = PCT_CHAR;
               cmd.bytes[1] = digit_char_ff;
               if (scan_pct) begin
                  cmd.count = 2'd2;
               end else begin
                  cmd.bytes[2] = req_item.in_byte;
                  cmd.count    = 2'd3;
               end
            end
         end
         default: begin
            if (scan_pct) begin
               cmd.count = 2'd0;
            end else begin
               cmd.bytes[0] = req_item.in_byte;
               cmd.count    = 2'd1;
            end
         end
      endcase
   end

   assign push     = accept && (cmd.count != 2'd0);
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= PEND_IDLE;
      end else begin
         pend_ff <= pend_in;
      end
      digit_char_ff  <= digit_char_in;
      digit_value_ff <= digit_value_in;
   end

endmodule

`default_nettype wire

// ----- rtl/pctd_queue.sv -----
// Command queue between the front end and the output sequencer.
// Depends on pctd_pkg and percent_decoder_core_defines.svh.
`default_nettype none
`include "percent_decoder_core_defines.svh"

module pctd_queue
   import pctd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output q_status_type q_status,
   output cmd_type      head_cmd
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cmd_type        mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == CW'(QUEUE_DEPTH));
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head_cmd       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `PCTD_ASSERT_NOW(a_no_push_full, push, !q_status.full, "push into full queue")
   `PCTD_ASSERT_NOW(a_no_pop_empty, pop, !q_status.empty, "pop from empty queue")
   `PCTD_ASSERT_NEXT(a_count_up, do_push && !do_pop,
      count_ff == $past(count_ff) + 1'b1, "count did not advance on push")
   `PCTD_ASSERT_NOW(a_cmd_nonempty, do_push, push_cmd.count != 2'd0, "empty command queued")

endmodule

`default_nettype wire

// ----- rtl/pctd_back.sv -----
// Output sequencer: walks the head command into the rsp register one byte per
// cycle while rsp_stall does not hold a valid result. Depends on pctd_pkg.
`default_nettype none

module pctd_back
   import pctd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire q_status_type q_status,
   input  wire cmd_type      head_cmd,
   output logic              pop,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_type           rsp_item
);

   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_item_ff, rsp_item_in;
   logic       advance;
   logic       final_byte;

   assign advance    = !q_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign final_byte = (idx_ff == head_cmd.count - 2'd1);
   assign pop        = advance && final_byte;

   always_comb begin
      idx_in       = idx_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance) begin
         rsp_valid_in         = 1'b1;
         rsp_item_in.out_byte = head_cmd.bytes[idx_ff];
         rsp_item_in.out_last = head_cmd.last && final_byte;
         idx_in               = final_byte ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire
